// ----- rtl/core/coo2csr_pkg.sv -----
package coo2csr_pkg;

    // Fixed field widths of the transaction payloads
    localparam int unsigned TILE_ROWS_W = 9;
    localparam int unsigned ROW_W       = 15;
    localparam int unsigned COL_W       = 15;
    localparam int unsigned VAL_W       = 16;
    localparam int unsigned ADDR_W      = 11;
    localparam int unsigned PTR_W       = 11;
    localparam int unsigned STATUS_W    = 3;

    localparam logic [TILE_ROWS_W-1:0] TILE_ROWS_RESET = 9'd128;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_DRAIN = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_ROW_OUT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_WORD     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic {
        CFG_TILE_ROWS     = 1'b0,
        CFG_TILE_BASE_ROW = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        KIND_PTR  = 1'b0,
        KIND_PAIR = 1'b1
    } t_word_kind;

    typedef struct packed {
        t_status                  status;
        t_word_kind               kind;
        logic [ADDR_W-1:0]        local_address;
        logic [PTR_W-1:0]         row_pointer;
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
        logic                     last;
    } t_result;

    // Datapath step requested by the controller in the current cycle
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_EXEC,
        STEP_CLR,
        STEP_CNT_RD,
        STEP_CNT_ROW,
        STEP_CNT_WR,
        STEP_PFX_RD,
        STEP_PFX_WR,
        STEP_SCT_RD,
        STEP_SCT_ROW,
        STEP_SCT_WR,
        STEP_DRN_RD,
        STEP_DRN_OUT
    } t_step;

    typedef struct packed {
        logic  take;
        t_step step;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    built;
        logic    clr_last;
        logic    elem_end;
        logic    pfx_end;
        logic    out_free;
    } t_dp_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CLR,
        S_CNT_RD,
        S_CNT_ROW,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_SCT_RD,
        S_SCT_ROW,
        S_SCT_WR,
        S_DRN_RD,
        S_DRN_OUT
    } t_state;

    // Interleaved local address: ((i>>3)<<4)+(i&7), kept to 11 bits
    function automatic logic [ADDR_W-1:0] iaddr(input logic [9:0] idx);
        return {idx[9:3], 1'b0, idx[2:0]};
    endfunction

endpackage

// ----- rtl/core/coo2csr_ctrl.sv -----
module coo2csr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  coo2csr_pkg::t_dp_sts i_sts,
    output coo2csr_pkg::t_dp_cmd o_cmd
);
    import coo2csr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd.take = 1'b0;
        o_cmd.step = STEP_NONE;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op == OP_DRAIN) begin
                    o_cmd.step = STEP_EXEC;
                    n_state    = i_sts.built ? S_DRN_RD : S_CLR;
                end else if (i_sts.out_free) begin
                    o_cmd.step = STEP_EXEC;
                    n_state    = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.step = STEP_CLR;
                if (i_sts.clr_last) begin
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                o_cmd.step = STEP_CNT_RD;
                n_state    = i_sts.elem_end ? S_PFX_RD : S_CNT_ROW;
            end
            S_CNT_ROW: begin
                o_cmd.step = STEP_CNT_ROW;
                n_state    = S_CNT_WR;
            end
            S_CNT_WR: begin
                o_cmd.step = STEP_CNT_WR;
                n_state    = S_CNT_RD;
            end
            S_PFX_RD: begin
                o_cmd.step = STEP_PFX_RD;
                n_state    = i_sts.pfx_end ? S_SCT_RD : S_PFX_WR;
            end
            S_PFX_WR: begin
                o_cmd.step = STEP_PFX_WR;
                n_state    = S_PFX_RD;
            end
            S_SCT_RD: begin
                o_cmd.step = STEP_SCT_RD;
                n_state    = i_sts.elem_end ? S_DRN_RD : S_SCT_ROW;
            end
            S_SCT_ROW: begin
                o_cmd.step = STEP_SCT_ROW;
                n_state    = S_SCT_WR;
            end
            S_SCT_WR: begin
                o_cmd.step = STEP_SCT_WR;
                n_state    = S_SCT_RD;
            end
            S_DRN_RD: begin
                o_cmd.step = STEP_DRN_RD;
                n_state    = S_DRN_OUT;
            end
            S_DRN_OUT: begin
                // hold the fetched word until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.step = STEP_DRN_OUT;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/coo2csr_datapath.sv -----
module coo2csr_datapath #(
    parameter int unsigned MAX_ROWS  = 256,
    parameter int unsigned MAX_ELEMS = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  coo2csr_pkg::t_dp_cmd                       i_cmd,
    output coo2csr_pkg::t_dp_sts                       o_sts,
    input  logic [1:0]                                 i_opcode,
    input  logic [coo2csr_pkg::ROW_W-1:0]              i_elem_row,
    input  logic [coo2csr_pkg::COL_W-1:0]              i_elem_col,
    input  logic signed [coo2csr_pkg::VAL_W-1:0]       i_elem_value,
    input  logic                                       i_cfg_valid,
    input  logic                                       i_cfg_index,
    input  logic [coo2csr_pkg::ROW_W-1:0]              i_cfg_data,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output coo2csr_pkg::t_result                       o_res
);
    import coo2csr_pkg::*;

    localparam int unsigned RW   = $clog2(MAX_ROWS);
    localparam int unsigned CAW  = $clog2(MAX_ROWS + 1);
    localparam int unsigned EAW  = $clog2(MAX_ELEMS);
    localparam int unsigned EW   = $clog2(MAX_ELEMS + 1);
    localparam int unsigned CW   = EW;
    localparam int unsigned IMAX = ((MAX_ROWS > MAX_ELEMS) ? MAX_ROWS : MAX_ELEMS) + 1;
    localparam int unsigned IW   = $clog2(IMAX + 1);
    localparam int unsigned DW   = $clog2(MAX_ROWS + MAX_ELEMS + 2);
    localparam int unsigned PR_W = COL_W + VAL_W;
    localparam int unsigned EL_W = RW + PR_W;

    // Storage
    logic [EL_W-1:0] mem_elem [MAX_ELEMS];
    logic [CW-1:0]   mem_cnt  [MAX_ROWS + 1];
    logic [CW-1:0]   mem_fill [MAX_ROWS];
    logic [PR_W-1:0] mem_pair [MAX_ELEMS];

    // Registers
    logic [TILE_ROWS_W-1:0]   r_tile_rows, n_tile_rows;
    logic [ROW_W-1:0]         r_base, n_base;
    logic [EW-1:0]            r_count, n_count;
    logic [DW-1:0]            r_drain, n_drain;
    logic                     r_built, n_built;
    logic [CW-1:0]            r_pair_total, n_pair_total;
    logic [IW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_acc, n_acc;
    logic                     r_out_valid, n_out_valid;
    t_result                  r_res;
    t_opcode                  r_op;
    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         r_col;
    logic signed [VAL_W-1:0]  r_val;
    logic [EL_W-1:0]          r_elem_q;
    logic [CW-1:0]            r_cnt_q;
    logic [CW-1:0]            r_fill_q;
    logic [PR_W-1:0]          r_pair_q;

    // Memory port controls
    logic             elem_we, elem_re;
    logic [EAW-1:0]   elem_waddr, elem_raddr;
    logic [EL_W-1:0]  elem_wdata;
    logic             cnt_we, cnt_re;
    logic [CAW-1:0]   cnt_waddr, cnt_raddr;
    logic [CW-1:0]    cnt_wdata;
    logic             fill_we, fill_re;
    logic [RW-1:0]    fill_waddr, fill_raddr;
    logic [CW-1:0]    fill_wdata;
    logic             pair_we, pair_re;
    logic [EAW-1:0]   pair_waddr, pair_raddr;
    logic [PR_W-1:0]  pair_wdata;

    // Decoded values
    logic [CAW-1:0]   rows_n;
    logic [ROW_W:0]   row_diff;
    logic             row_out;
    logic             store_full;
    logic [RW-1:0]    eq_row;
    logic [CAW-1:0]   eq_row_c;
    logic             eq_hit;
    logic [CW-1:0]    pfx_sum;
    logic [CW-1:0]    dest;
    logic [DW-1:0]    total;
    logic [DW-1:0]    pair_k;
    logic [DW-1:0]    word_idx;
    logic [DW+9:0]    word_idx_w;
    logic [CW+10:0]   ptr_w;
    logic             d_is_ptr;
    logic             out_free;
    logic             res_wr;
    t_result          res_data;

    // Saturate the row count at the store's depth
    always_comb begin
        if (32'(r_tile_rows) > MAX_ROWS) begin
            rows_n = CAW'(MAX_ROWS);
        end else begin
            rows_n = CAW'(r_tile_rows);
        end
    end

    assign row_diff   = {1'b0, r_row} - {1'b0, r_base};
    assign row_out    = row_diff[ROW_W] || (row_diff[ROW_W-1:0] >= ROW_W'(rows_n));
    assign store_full = 32'(r_count) >= MAX_ELEMS;

    assign eq_row   = r_elem_q[EL_W-1 -: RW];
    assign eq_row_c = CAW'(eq_row);
    assign eq_hit   = eq_row_c < rows_n;
    assign pfx_sum  = r_acc + r_cnt_q;
    assign dest     = r_cnt_q + r_fill_q;

    assign total      = DW'(rows_n) + DW'(r_pair_total) + DW'(1);
    assign d_is_ptr   = r_drain <= DW'(rows_n);
    assign pair_k     = r_drain - DW'(rows_n) - DW'(1);
    assign word_idx   = d_is_ptr ? r_drain : pair_k;
    assign word_idx_w = {10'b0, word_idx};
    assign ptr_w      = {11'b0, r_cnt_q};

    assign out_free = !r_out_valid || i_ready;

    assign o_sts.op       = r_op;
    assign o_sts.built    = r_built;
    assign o_sts.clr_last = r_idx == IW'(rows_n);
    assign o_sts.elem_end = r_idx >= IW'(r_count);
    assign o_sts.pfx_end  = r_idx > IW'(rows_n);
    assign o_sts.out_free = out_free;

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        n_tile_rows  = r_tile_rows;
        n_base       = r_base;
        n_count      = r_count;
        n_drain      = r_drain;
        n_built      = r_built;
        n_pair_total = r_pair_total;
        n_idx        = r_idx;
        n_acc        = r_acc;

        elem_we    = 1'b0;
        elem_re    = 1'b0;
        elem_waddr = r_count[EAW-1:0];
        elem_raddr = r_idx[EAW-1:0];
        elem_wdata = {row_diff[RW-1:0], r_col, r_val};
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_waddr  = r_idx[CAW-1:0];
        cnt_raddr  = r_idx[CAW-1:0];
        cnt_wdata  = '0;
        fill_we    = 1'b0;
        fill_re    = 1'b0;
        fill_waddr = r_idx[RW-1:0];
        fill_raddr = eq_row;
        fill_wdata = '0;
        pair_we    = 1'b0;
        pair_re    = 1'b0;
        pair_waddr = dest[EAW-1:0];
        pair_raddr = pair_k[EAW-1:0];
        pair_wdata = r_elem_q[PR_W-1:0];

        res_wr                 = 1'b0;
        res_data.status        = ST_ACCEPTED;
        res_data.kind          = KIND_PTR;
        res_data.local_address = '0;
        res_data.row_pointer   = '0;
        res_data.col           = '0;
        res_data.value         = '0;
        res_data.last          = 1'b0;

        case (i_cmd.step)
            STEP_EXEC: begin
                case (r_op)
                    OP_LOAD: begin
                        res_wr = 1'b1;
                        if (row_out) begin
                            res_data.status = ST_ROW_OUT;
                        end else if (store_full) begin
                            res_data.status = ST_FULL;
                        end else begin
                            elem_we = 1'b1;
                            n_count = r_count + EW'(1);
                            n_built = 1'b0;
                            n_drain = '0;
                        end
                    end
                    OP_DRAIN: begin
                        n_idx = '0;
                    end
                    OP_CLEAR: begin
                        res_wr  = 1'b1;
                        n_count = '0;
                        n_drain = '0;
                        n_built = 1'b0;
                    end
                    default: begin
                        res_wr = 1'b1;
                    end
                endcase
            end
            STEP_CLR: begin
                cnt_we = 1'b1;
                if (r_idx < IW'(rows_n)) begin
                    fill_we = 1'b1;
                end
                if (r_idx == IW'(rows_n)) begin
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            STEP_CNT_RD: begin
                if (r_idx >= IW'(r_count)) begin
                    n_idx = IW'(1);
                    n_acc = '0;
                end else begin
                    elem_re = 1'b1;
                end
            end
            STEP_CNT_ROW: begin
                cnt_re    = 1'b1;
                cnt_raddr = eq_row_c + CAW'(1);
            end
            STEP_CNT_WR: begin
                cnt_we    = eq_hit;
                cnt_waddr = eq_row_c + CAW'(1);
                cnt_wdata = r_cnt_q + CW'(1);
                n_idx     = r_idx + IW'(1);
            end
            STEP_PFX_RD: begin
                if (r_idx > IW'(rows_n)) begin
                    n_pair_total = r_acc;
                    n_idx        = '0;
                end else begin
                    cnt_re = 1'b1;
                end
            end
            STEP_PFX_WR: begin
                cnt_we    = 1'b1;
                cnt_wdata = pfx_sum;
                n_acc     = pfx_sum;
                n_idx     = r_idx + IW'(1);
            end
            STEP_SCT_RD: begin
                if (r_idx >= IW'(r_count)) begin
                    n_built = 1'b1;
                end else begin
                    elem_re = 1'b1;
                end
            end
            STEP_SCT_ROW: begin
                cnt_re    = 1'b1;
                cnt_raddr = eq_row_c;
                fill_re   = 1'b1;
            end
            STEP_SCT_WR: begin
                if (eq_hit) begin
                    pair_we    = 32'(dest) < MAX_ELEMS;
                    fill_we    = 1'b1;
                    fill_waddr = eq_row;
                    fill_wdata = r_fill_q + CW'(1);
                end
                n_idx = r_idx + IW'(1);
            end
            STEP_DRN_RD: begin
                cnt_re    = 1'b1;
                cnt_raddr = r_drain[CAW-1:0];
                pair_re   = 1'b1;
            end
            STEP_DRN_OUT: begin
                res_wr = 1'b1;
                if (r_drain >= total) begin
                    res_data.status = ST_EMPTY;
                end else begin
                    res_data.status        = ST_WORD;
                    res_data.local_address = iaddr(word_idx_w[9:0]);
                    res_data.last          = (r_drain + DW'(1)) == total;
                    if (d_is_ptr) begin
                        res_data.row_pointer = ptr_w[PTR_W-1:0];
                    end else begin
                        res_data.kind  = KIND_PAIR;
                        res_data.col   = r_pair_q[PR_W-1 -: COL_W];
                        res_data.value = r_pair_q[VAL_W-1:0];
                    end
                    n_drain = r_drain + DW'(1);
                end
            end
            default: begin
            end
        endcase

        // User writes registers only while idle, unenforced; writes drop the built form
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TILE_ROWS:     n_tile_rows = i_cfg_data[TILE_ROWS_W-1:0];
                CFG_TILE_BASE_ROW: n_base      = i_cfg_data;
                default: begin
                end
            endcase
            n_built = 1'b0;
            n_drain = '0;
        end

        if (res_wr) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_rows <= TILE_ROWS_RESET;
            r_base      <= '0;
            r_count     <= '0;
            r_drain     <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tile_rows <= n_tile_rows;
            r_base      <= n_base;
            r_count     <= n_count;
            r_drain     <= n_drain;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair_total <= n_pair_total;
        r_idx        <= n_idx;
        r_acc        <= n_acc;
        if (res_wr) begin
            r_res <= res_data;
        end
        if (i_cmd.take) begin
            r_op  <= t_opcode'(i_opcode);
            r_row <= i_elem_row;
            r_col <= i_elem_col;
            r_val <= i_elem_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            mem_elem[elem_waddr] <= elem_wdata;
        end
        if (elem_re) begin
            r_elem_q <= mem_elem[elem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_q <= mem_cnt[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            mem_fill[fill_waddr] <= fill_wdata;
        end
        if (fill_re) begin
            r_fill_q <= mem_fill[fill_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            mem_pair[pair_waddr] <= pair_wdata;
        end
        if (pair_re) begin
            r_pair_q <= mem_pair[pair_raddr];
        end
    end

endmodule

// ----- rtl/core/coo_to_csr_tile_converter.sv -----
// COO to CSR converter for one row tile of a sparse matrix.
// Input channel (i_valid/o_ready): one transaction is a load of one element
// (row, column, value), a drain request for the next output word, a clear or a no-op.
// Output channel (o_valid/i_ready): exactly one result transaction per input
// transaction, in order: a load, clear or no-op status, or one drain word (row
// pointer or col/value pair with interleaved local address and last flag) or empty status.
// Configuration channel (i_cfg_valid/o_cfg_ready, always ready): register 0 is
// the tile row count, register 1 the tile's base row; write only while idle.
// Timing: a load, clear or ignored opcode is written to the result register in
// the execute state after acceptance; a drain on a built tile passes the execute
// and memory read states and is written in the drain output state. The first
// drain after a stored load, a clear or a register write first runs the build
// sequence: a clearing sweep of the count and fill memories, a count pass over
// the elements, a prefix-sum pass over the rows and a scatter pass over the
// elements, all bound by the single port pair of each memory.
// One transaction is worked on at a time; the next one is accepted as soon as
// the current result sits in the output register.
// Reset: tile rows 128, base row 0, empty element store; no clearing pass.
// Receiver stall: the result holds in the output register; one further
// transaction is taken and its result waits until the register frees up.
module coo_to_csr_tile_converter #(
    parameter int unsigned MAX_ROWS  = 256,
    parameter int unsigned MAX_ELEMS = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input transactions
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [1:0]                              i_opcode,
    input  logic [coo2csr_pkg::ROW_W-1:0]           i_elem_row,
    input  logic [coo2csr_pkg::COL_W-1:0]           i_elem_col,
    input  logic signed [coo2csr_pkg::VAL_W-1:0]    i_elem_value,
    // result transactions
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [coo2csr_pkg::STATUS_W-1:0]        o_status,
    output logic                                    o_word_kind,
    output logic [coo2csr_pkg::ADDR_W-1:0]          o_local_address,
    output logic [coo2csr_pkg::PTR_W-1:0]           o_row_pointer,
    output logic [coo2csr_pkg::COL_W-1:0]           o_out_col,
    output logic signed [coo2csr_pkg::VAL_W-1:0]    o_out_value,
    output logic                                    o_last,
    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic                                    i_cfg_index,
    input  logic [coo2csr_pkg::ROW_W-1:0]           i_cfg_data
);
    import coo2csr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result res;

    // Configuration writes go straight into the tile registers, so the port never stalls
    assign o_cfg_ready = 1'b1;

    // Sequencer: accepts transactions and steps the build and drain passes
    coo2csr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Memories, counters, tile registers and the output register
    coo2csr_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_ELEMS (MAX_ELEMS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_opcode),
        .i_elem_row   (i_elem_row),
        .i_elem_col   (i_elem_col),
        .i_elem_value (i_elem_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (res)
    );

    // Unpack the result register onto the field ports
    assign o_status        = res.status;
    assign o_word_kind     = res.kind;
    assign o_local_address = res.local_address;
    assign o_row_pointer   = res.row_pointer;
    assign o_out_col       = res.col;
    assign o_out_value     = res.value;
    assign o_last          = res.last;

endmodule
